>>> design/swlff_pkg.sv
package swlff_pkg;

  localparam int unsigned HEADER_BYTES = 40;

  localparam int unsigned POS_W  = 24;
  localparam int unsigned LEN_W  = 25;
  localparam int unsigned WORD_W = 32;
  localparam int unsigned FILL_W = 3;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [WORD_W-1:0] SYNC_WORD = 32'h0004_C453;
  localparam logic [FILL_W-1:0] FILL_FULL = 3'd4;

  // header offsets of each big-endian word
  localparam int unsigned OFS_LENGTH     = 4;
  localparam int unsigned OFS_TYPE       = 8;
  localparam int unsigned OFS_SUBTYPE    = 12;
  localparam int unsigned OFS_SEQUENCE   = 16;
  localparam int unsigned OFS_COMPRESSED = 32;

  // byte position at which each word is complete
  localparam logic [POS_W-1:0] POS_SYNC_END   = POS_W'(OFS_LENGTH);
  localparam logic [POS_W-1:0] POS_LENGTH     = POS_W'(OFS_LENGTH + 3);
  localparam logic [POS_W-1:0] POS_TYPE       = POS_W'(OFS_TYPE + 3);
  localparam logic [POS_W-1:0] POS_SUBTYPE    = POS_W'(OFS_SUBTYPE + 3);
  localparam logic [POS_W-1:0] POS_SEQUENCE   = POS_W'(OFS_SEQUENCE + 3);
  localparam logic [POS_W-1:0] POS_COMPRESSED = POS_W'(OFS_COMPRESSED + 3);
  localparam logic [POS_W-1:0] POS_HDR_LAST   = POS_W'(HEADER_BYTES - 1);
  localparam logic [POS_W-1:0] POS_BODY_FIRST = POS_W'(HEADER_BYTES);

  localparam logic [CFG_IDX_W-1:0] CFG_WANTED_TYPE    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WANTED_SUBTYPE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_LENGTH     = 2'd2;

  localparam logic [WORD_W-1:0] RST_WANTED_TYPE    = 32'd47;
  localparam logic [WORD_W-1:0] RST_WANTED_SUBTYPE = 32'd4701;
  localparam logic [LEN_W-1:0]  RST_MAX_LENGTH     = LEN_W'(16 * 1024 * 1024);

  typedef struct packed {
    logic [WORD_W-1:0] wanted_type;
    logic [WORD_W-1:0] wanted_subtype;
    logic [LEN_W-1:0]  max_frame_length;
  } cfg_t;

  typedef struct packed {
    logic [7:0]        body_byte;
    logic              first_of_frame;
    logic              last_of_frame;
    logic [WORD_W-1:0] frame_sequence;
    logic              is_compressed;
    logic [WORD_W-1:0] frame_number;
  } res_t;

endpackage

>>> design/swlff_parser.sv
module swlff_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               accept,
  input  logic [7:0]         stream_byte,
  input  swlff_pkg::cfg_t    cfg,
  output logic               res_valid,
  output swlff_pkg::res_t    res
);

  typedef enum logic [1:0] {
    PH_HUNT   = 2'd0,
    PH_HEADER = 2'd1,
    PH_BODY   = 2'd2
  } phase_t;

  phase_t                            phase_r, phase_nxt;
  logic [swlff_pkg::WORD_W-1:0]      window_r, window_nxt;
  logic [swlff_pkg::FILL_W-1:0]      fill_r, fill_nxt;
  logic [swlff_pkg::POS_W-1:0]       pos_r, pos_nxt;
  logic [swlff_pkg::LEN_W-1:0]       total_len_r, total_len_nxt;
  logic [swlff_pkg::WORD_W-1:0]      shift_r, shift_nxt;
  logic                              matches_r, matches_nxt;
  logic [swlff_pkg::WORD_W-1:0]      seq_r, seq_nxt;
  logic                              comp_r, comp_nxt;
  logic [swlff_pkg::WORD_W-1:0]      count_r, count_nxt;

  logic [swlff_pkg::WORD_W-1:0]      hdr_word;
  logic [swlff_pkg::WORD_W-1:0]      hunt_word;
  logic [swlff_pkg::FILL_W-1:0]      hunt_fill;
  logic                              bad_len;
  logic [swlff_pkg::LEN_W-1:0]       pos_inc;
  logic                              body_last;

  assign hdr_word  = {shift_r[swlff_pkg::WORD_W-9:0], stream_byte};
  assign hunt_word = {window_r[swlff_pkg::WORD_W-9:0], stream_byte};
  assign hunt_fill = (fill_r < swlff_pkg::FILL_FULL) ? fill_r + 1'b1 : fill_r;
  assign bad_len   = (hdr_word < swlff_pkg::WORD_W'(swlff_pkg::HEADER_BYTES)) ||
                     (hdr_word > {{(swlff_pkg::WORD_W-swlff_pkg::LEN_W){1'b0}},
                                  cfg.max_frame_length});
  assign pos_inc   = {1'b0, pos_r} + 1'b1;
  assign body_last = (pos_inc >= total_len_r);

  always_comb begin
    phase_nxt     = phase_r;
    window_nxt    = window_r;
    fill_nxt      = fill_r;
    pos_nxt       = pos_r;
    total_len_nxt = total_len_r;
    shift_nxt     = shift_r;
    matches_nxt   = matches_r;
    seq_nxt       = seq_r;
    comp_nxt      = comp_r;
    count_nxt     = count_r;
    res_valid     = 1'b0;

    res.body_byte      = stream_byte;
    res.first_of_frame = (pos_r == swlff_pkg::POS_BODY_FIRST);
    res.last_of_frame  = body_last;
    res.frame_sequence = seq_r;
    res.is_compressed  = comp_r;
    res.frame_number   = count_r;

    if (accept) begin
      case (phase_r)
        PH_HEADER: begin
          shift_nxt = hdr_word;
          pos_nxt   = pos_inc[swlff_pkg::POS_W-1:0];
          if (pos_r == swlff_pkg::POS_LENGTH && bad_len) begin
            // drop the sync word, the length bytes become the hunt window
            window_nxt = hdr_word;
            fill_nxt   = swlff_pkg::FILL_FULL;
            phase_nxt  = PH_HUNT;
            pos_nxt    = '0;
            if (hdr_word == swlff_pkg::SYNC_WORD) begin
              phase_nxt   = PH_HEADER;
              pos_nxt     = swlff_pkg::POS_SYNC_END;
              shift_nxt   = '0;
              matches_nxt = 1'b0;
            end
          end else begin
            case (pos_r)
              swlff_pkg::POS_LENGTH:     total_len_nxt = hdr_word[swlff_pkg::LEN_W-1:0];
              swlff_pkg::POS_TYPE:       matches_nxt = (hdr_word == cfg.wanted_type);
              swlff_pkg::POS_SUBTYPE:    matches_nxt = matches_r &&
                                                       (hdr_word == cfg.wanted_subtype);
              swlff_pkg::POS_SEQUENCE:   seq_nxt = hdr_word;
              swlff_pkg::POS_COMPRESSED: comp_nxt = (hdr_word == swlff_pkg::WORD_W'(1));
              default: ;
            endcase
            if (pos_r == swlff_pkg::POS_HDR_LAST) begin
              if (matches_r) count_nxt = count_r + 1'b1;
              if (total_len_r <= swlff_pkg::LEN_W'(swlff_pkg::HEADER_BYTES)) begin
                // header-only frame
                phase_nxt  = PH_HUNT;
                window_nxt = '0;
                fill_nxt   = '0;
                pos_nxt    = '0;
              end else begin
                phase_nxt = PH_BODY;
              end
            end
          end
        end
        PH_BODY: begin
          res_valid = matches_r;
          if (body_last) begin
            phase_nxt  = PH_HUNT;
            window_nxt = '0;
            fill_nxt   = '0;
            pos_nxt    = '0;
          end else begin
            pos_nxt = pos_inc[swlff_pkg::POS_W-1:0];
          end
        end
        default: begin
          phase_nxt  = PH_HUNT;
          window_nxt = hunt_word;
          fill_nxt   = hunt_fill;
          if (hunt_fill >= swlff_pkg::FILL_FULL && hunt_word == swlff_pkg::SYNC_WORD) begin
            phase_nxt   = PH_HEADER;
            pos_nxt     = swlff_pkg::POS_SYNC_END;
            shift_nxt   = '0;
            matches_nxt = 1'b0;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_HUNT;
      window_r    <= '0;
      fill_r      <= '0;
      pos_r       <= '0;
      total_len_r <= '0;
      shift_r     <= '0;
      matches_r   <= 1'b0;
      seq_r       <= '0;
      comp_r      <= 1'b0;
      count_r     <= '0;
    end else begin
      phase_r     <= phase_nxt;
      window_r    <= window_nxt;
      fill_r      <= fill_nxt;
      pos_r       <= pos_nxt;
      total_len_r <= total_len_nxt;
      shift_r     <= shift_nxt;
      matches_r   <= matches_nxt;
      seq_r       <= seq_nxt;
      comp_r      <= comp_nxt;
      count_r     <= count_nxt;
    end
  end

  a_hdr_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_HEADER |->
      pos_r >= swlff_pkg::POS_SYNC_END && pos_r <= swlff_pkg::POS_HDR_LAST)
    else $error("header byte position out of range");

  a_body_len: assert property (@(posedge clk) disable iff (!rst_n)
    phase_r == PH_BODY |->
      total_len_r > swlff_pkg::LEN_W'(swlff_pkg::HEADER_BYTES) &&
      pos_r >= swlff_pkg::POS_BODY_FIRST && pos_inc <= total_len_r)
    else $error("body position beyond frame length");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    count_r != $past(count_r) |->
      $past(phase_r) == PH_HEADER && $past(pos_r) == swlff_pkg::POS_HDR_LAST &&
      $past(matches_r))
    else $error("frame count moved outside header end of a matching frame");

endmodule

>>> design/swlff_out_buf.sv
module swlff_out_buf (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            res_valid,
  input  swlff_pkg::res_t res,
  output logic            full,
  output logic            out_valid,
  input  logic            out_stall,
  output swlff_pkg::res_t out_res
);

  logic            main_valid_r;
  swlff_pkg::res_t main_r;
  logic            skid_valid_r;
  swlff_pkg::res_t skid_r;
  logic            take;

  assign take      = main_valid_r && !out_stall;
  assign full      = skid_valid_r;
  assign out_valid = main_valid_r;
  assign out_res   = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      // input is stalled while the skid entry is occupied
      if (take) begin
        main_r       <= skid_r;
        skid_valid_r <= 1'b0;
      end
    end else if (!main_valid_r || take) begin
      main_valid_r <= res_valid;
      main_r       <= res;
    end else if (res_valid) begin
      skid_valid_r <= 1'b1;
      skid_r       <= res;
    end
  end

  a_skid_behind_main: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> main_valid_r)
    else $error("skid entry held without an output request");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r && !take |=> skid_valid_r && skid_r == $past(skid_r))
    else $error("skid entry lost while output stalled");

endmodule

>>> design/sync_word_length_frame_filter.sv
// Byte-stream deframer: hunts for the sync word 00 04 C4 53, parses the 40-byte
// big-endian header and passes the body bytes of frames whose type and subtype
// match cfg registers 0 and 1, one result per body byte. Throughput is one
// stream byte per clock while in_stall is low; each byte is handled by the
// parser state registers and its result is registered in a two-entry output
// buffer. in_stall rises only when both buffer entries are held by a stalled
// output. Config writes (index 0 type, 1 subtype, 2 max frame length) are
// always ready and should be done while the stream is idle; a frame's match
// is decided when its header words arrive.
module sync_word_length_frame_filter (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [7:0]                         in_stream_byte,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [7:0]                         out_body_byte,
  output logic                               out_first_of_frame,
  output logic                               out_last_of_frame,
  output logic [swlff_pkg::WORD_W-1:0]       out_frame_sequence,
  output logic                               out_is_compressed,
  output logic [swlff_pkg::WORD_W-1:0]       out_frame_number,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [swlff_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [swlff_pkg::WORD_W-1:0]       cfg_data
);

  swlff_pkg::cfg_t cfg_r;
  swlff_pkg::res_t res;
  swlff_pkg::res_t out_res;
  logic            res_valid;
  logic            buf_full;
  logic            accept;

  assign cfg_ready = 1'b1;
  assign in_stall  = buf_full;
  assign accept    = in_valid && !buf_full;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.wanted_type      <= swlff_pkg::RST_WANTED_TYPE;
      cfg_r.wanted_subtype   <= swlff_pkg::RST_WANTED_SUBTYPE;
      cfg_r.max_frame_length <= swlff_pkg::RST_MAX_LENGTH;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        swlff_pkg::CFG_WANTED_TYPE:    cfg_r.wanted_type    <= cfg_data;
        swlff_pkg::CFG_WANTED_SUBTYPE: cfg_r.wanted_subtype <= cfg_data;
        swlff_pkg::CFG_MAX_LENGTH:
          cfg_r.max_frame_length <= cfg_data[swlff_pkg::LEN_W-1:0];
        default: ;
      endcase
    end
  end

  swlff_parser u_parser (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .stream_byte (in_stream_byte),
    .cfg         (cfg_r),
    .res_valid   (res_valid),
    .res         (res)
  );

  swlff_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_valid (res_valid),
    .res       (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign out_body_byte      = out_res.body_byte;
  assign out_first_of_frame = out_res.first_of_frame;
  assign out_last_of_frame  = out_res.last_of_frame;
  assign out_frame_sequence = out_res.frame_sequence;
  assign out_is_compressed  = out_res.is_compressed;
  assign out_frame_number   = out_res.frame_number;

endmodule
